### rtl/core/gro_pkg.sv
package gro_pkg;

  localparam int MAX_WIDTH_DEF       = 256;
  localparam int MAX_HEIGHT_DEF      = 256;
  localparam int RANGE_FRAC_BITS_DEF = 4;

  localparam int CRD_W      = 16;
  localparam int ERR_W      = CRD_W + 2;
  localparam int CELL_W     = 8;
  localparam int RANGE_W    = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;
  localparam int IN_DATA_W  = 88;
  localparam int OUT_DATA_W = 16;

  localparam logic [RANGE_W-1:0] RANGE_MAX = 13'd8191;

  localparam logic [CFG_IDX_W-1:0] REG_MAP_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAP_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OBSTACLE   = 2'd2;

  localparam logic [CFG_DATA_W-1:0] MAP_WIDTH_RST  = 9'd256;
  localparam logic [CFG_DATA_W-1:0] MAP_HEIGHT_RST = 9'd256;
  localparam logic [CELL_W-1:0]     OBSTACLE_RST   = 8'd0;

  localparam logic KIND_CELL = 1'b0;
  localparam logic KIND_RAY  = 1'b1;

  typedef struct packed {
    logic              kind;
    logic [7:0]        cell_x;
    logic [7:0]        cell_y;
    logic [CELL_W-1:0] cell_value;
    logic [CRD_W-1:0]  start_x;
    logic [CRD_W-1:0]  start_y;
    logic [CRD_W-1:0]  end_x;
    logic [CRD_W-1:0]  end_y;
  } gro_item_t;

  // extents already clamped to 1..MAX
  typedef struct packed {
    logic [CRD_W-1:0]  width;
    logic [CRD_W-1:0]  height;
    logic [CELL_W-1:0] obstacle;
  } gro_cfg_t;

  typedef struct packed {
    logic               hit;
    logic [RANGE_W-1:0] range_q4;
  } gro_res_t;

endpackage

### rtl/core/gro_grid_mem.sv
module gro_grid_mem #(
  parameter int ADDR_W = 16
) (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [ADDR_W-1:0]         waddr_i,
  input  logic [gro_pkg::CELL_W-1:0] wdata_i,
  input  logic                      re_i,
  input  logic [ADDR_W-1:0]         raddr_i,
  output logic [gro_pkg::CELL_W-1:0] rdata_o
);
  import gro_pkg::*;

  logic [CELL_W-1:0] mem_q [2**ADDR_W];
  logic [CELL_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/gro_isqrt.sv
module gro_isqrt #(
  parameter int IN_W = 25
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic [IN_W-1:0]         radicand_i,
  output logic                    done_o,
  output logic [(IN_W+1)/2-1:0]   root_o
);
  import gro_pkg::*;

  localparam int SW    = IN_W + (IN_W % 2);
  localparam int RW    = SW / 2;
  localparam int CNT_W = $clog2(RW + 1);

  logic             busy_q;
  logic             done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [SW-1:0]    n_q;
  logic [RW:0]      rem_q;
  logic [RW-1:0]    root_q;

  logic [RW+1:0] rem_sh;
  logic [RW+1:0] trial;
  logic          take;

  // one result bit per cycle, two radicand bits shifted in
  assign rem_sh = {rem_q[RW-1:0], n_q[SW-1:SW-2]};
  assign trial  = {root_q, 2'b01};
  assign take   = rem_sh >= trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(RW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      n_q    <= SW'(radicand_i);
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      n_q    <= n_q << 2;
      rem_q  <= take ? (RW+1)'(rem_sh - trial) : (RW+1)'(rem_sh);
      root_q <= {root_q[RW-2:0], take};
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

### rtl/core/gro_ray_ctrl.sv
module gro_ray_ctrl #(
  parameter int MAX_WIDTH       = gro_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT      = gro_pkg::MAX_HEIGHT_DEF,
  parameter int RANGE_FRAC_BITS = gro_pkg::RANGE_FRAC_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  gro_pkg::gro_item_t in_item_i,
  input  gro_pkg::gro_cfg_t  cfg_i,
  output logic              res_valid_o,
  input  logic              res_ready_i,
  output gro_pkg::gro_res_t  res_o
);
  import gro_pkg::*;

  localparam int XW   = $clog2(MAX_WIDTH);
  localparam int YW   = $clog2(MAX_HEIGHT);
  localparam int AW   = XW + YW;
  localparam int DW   = (XW > YW) ? XW : YW;
  localparam int NW   = 2 * DW + 1 + 2 * RANGE_FRAC_BITS;
  localparam int RW   = (NW + 1) / 2;
  localparam int SATW = (RW > RANGE_W) ? RW : RANGE_W;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_CHK    = 4'd1;
  localparam logic [3:0] S_PREP   = 4'd2;
  localparam logic [3:0] S_ORIENT = 4'd3;
  localparam logic [3:0] S_LIM    = 4'd4;
  localparam logic [3:0] S_WALK   = 4'd5;
  localparam logic [3:0] S_DIST   = 4'd6;
  localparam logic [3:0] S_SQ     = 4'd7;
  localparam logic [3:0] S_SUM    = 4'd8;
  localparam logic [3:0] S_ROOT   = 4'd9;
  localparam logic [3:0] S_OUT    = 4'd10;

  localparam logic signed [CRD_W-1:0] ONE = 1;

  logic [3:0] state_q;

  logic signed [CRD_W-1:0] xs_q, ys_q, xe_q, ye_q;
  logic signed [CRD_W:0]   dx_q, dy_q;
  logic [CRD_W-1:0]        da_q, db_q;
  logic                    xmajor_q, san_q, sbn_q;
  logic signed [CRD_W-1:0] a_q, b_q, ae_q, lim_q, amax_q, bmax_q;
  logic signed [ERR_W-1:0] err_q, ddiff_q;
  logic                    term_q, term_hit_q;
  logic                    cv_q;
  logic signed [CRD_W-1:0] ca_q, cb_q, pa_q, pb_q;
  logic [DW-1:0]           ex_q, ey_q;
  logic [2*DW-1:0]         exx_q, eyy_q;
  gro_res_t                res_q;

  logic                    acc;
  logic                    mem_we;
  logic [AW-1:0]           waddr;
  logic signed [CRD_W-1:0] w_s, h_s;
  logic                    off_map;
  logic signed [CRD_W:0]   adx, ady;
  logic                    beyond, issue, b_move, b_out, term_hit_a, obst;
  logic signed [CRD_W-1:0] rd_x, rd_y, a_step, b_step;
  logic [AW-1:0]           raddr;
  logic [CELL_W-1:0]       rd_data;
  logic signed [ERR_W-1:0] err_dec, err_alt;
  logic signed [CRD_W-1:0] px, py, exs, eys, exa, eya;
  logic [2*DW:0]           d2;
  logic [NW-1:0]           radicand;
  logic                    sq_start, sq_done;
  logic [RW-1:0]           sq_root;
  logic [SATW-1:0]         root_ext;
  logic [RANGE_W-1:0]      range_sat;

  assign in_ready_o  = (state_q == S_IDLE);
  assign acc         = in_valid_i && in_ready_o;
  assign res_valid_o = (state_q == S_OUT);
  assign res_o       = res_q;

  assign mem_we = acc && (in_item_i.kind == KIND_CELL) &&
                  (in_item_i.cell_x < MAX_WIDTH) && (in_item_i.cell_y < MAX_HEIGHT);
  assign waddr  = {XW'(in_item_i.cell_x), YW'(in_item_i.cell_y)};

  assign w_s     = $signed(cfg_i.width);
  assign h_s     = $signed(cfg_i.height);
  assign off_map = xs_q[CRD_W-1] || ys_q[CRD_W-1] || (xs_q >= w_s) || (ys_q >= h_s);

  assign adx = dx_q[CRD_W] ? -dx_q : dx_q;
  assign ady = dy_q[CRD_W] ? -dy_q : dy_q;

  // line stepper, one cell read issued per cycle
  assign beyond     = san_q ? (a_q < lim_q) : (a_q > lim_q);
  assign issue      = (state_q == S_WALK) && !term_q && !beyond;
  assign rd_x       = xmajor_q ? a_q : b_q;
  assign rd_y       = xmajor_q ? b_q : a_q;
  assign raddr      = {rd_x[XW-1:0], rd_y[YW-1:0]};
  assign err_dec    = err_q - $signed({2'b00, db_q});
  assign err_alt    = err_q + ddiff_q;
  assign b_move     = err_dec[ERR_W-1];
  assign b_step     = sbn_q ? (b_q - ONE) : (b_q + ONE);
  assign b_out      = b_move && (b_step[CRD_W-1] || (b_step >= bmax_q));
  assign a_step     = san_q ? (a_q - ONE) : (a_q + ONE);
  assign term_hit_a = san_q ? (a_q >= ae_q) : (a_q <= ae_q);
  assign obst       = cv_q && (rd_data == cfg_i.obstacle);

  assign px  = xmajor_q ? pa_q : pb_q;
  assign py  = xmajor_q ? pb_q : pa_q;
  assign exs = px - xs_q;
  assign eys = py - ys_q;
  assign exa = exs[CRD_W-1] ? -exs : exs;
  assign eya = eys[CRD_W-1] ? -eys : eys;

  assign d2        = (2*DW+1)'(exx_q) + (2*DW+1)'(eyy_q);
  assign radicand  = NW'(d2) << (2 * RANGE_FRAC_BITS);
  assign sq_start  = (state_q == S_SUM);
  assign root_ext  = SATW'(sq_root);
  assign range_sat = (root_ext > SATW'(RANGE_MAX)) ? RANGE_MAX : root_ext[RANGE_W-1:0];

  gro_grid_mem #(
    .ADDR_W (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (waddr),
    .wdata_i (in_item_i.cell_value),
    .re_i    (issue),
    .raddr_i (raddr),
    .rdata_o (rd_data)
  );

  gro_isqrt #(
    .IN_W (NW)
  ) u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sq_start),
    .radicand_i (radicand),
    .done_o     (sq_done),
    .root_o     (sq_root)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      term_q  <= 1'b0;
      cv_q    <= 1'b0;
    end else begin
      cv_q <= issue;
      case (state_q)
        S_IDLE: begin
          if (acc && (in_item_i.kind == KIND_RAY)) begin
            state_q <= S_CHK;
          end
        end
        S_CHK:    state_q <= off_map ? S_OUT : S_PREP;
        S_PREP:   state_q <= S_ORIENT;
        S_ORIENT: state_q <= S_LIM;
        S_LIM: begin
          state_q <= S_WALK;
          term_q  <= 1'b0;
        end
        S_WALK: begin
          if (obst) begin
            state_q <= S_DIST;
          end else if (term_q && !cv_q) begin
            state_q <= term_hit_q ? S_DIST : S_OUT;
          end
          if (!term_q && (beyond || b_out)) begin
            term_q <= 1'b1;
          end
        end
        S_DIST: state_q <= S_SQ;
        S_SQ:   state_q <= S_SUM;
        S_SUM:  state_q <= S_ROOT;
        S_ROOT: begin
          if (sq_done) begin
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          if (res_ready_i) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (acc) begin
          xs_q <= $signed(in_item_i.start_x);
          ys_q <= $signed(in_item_i.start_y);
          xe_q <= $signed(in_item_i.end_x);
          ye_q <= $signed(in_item_i.end_y);
        end
      end
      S_CHK: begin
        dx_q <= {xe_q[CRD_W-1], xe_q} - {xs_q[CRD_W-1], xs_q};
        dy_q <= {ye_q[CRD_W-1], ye_q} - {ys_q[CRD_W-1], ys_q};
        if (off_map) begin
          res_q <= '{hit: 1'b1, range_q4: '0};
        end
      end
      S_PREP: begin
        da_q <= adx[CRD_W-1:0];
        db_q <= ady[CRD_W-1:0];
      end
      S_ORIENT: begin
        xmajor_q <= (da_q >= db_q);
        if (da_q >= db_q) begin
          a_q    <= xs_q;
          b_q    <= ys_q;
          ae_q   <= xe_q;
          san_q  <= dx_q[CRD_W];
          sbn_q  <= dy_q[CRD_W];
          amax_q <= w_s;
          bmax_q <= h_s;
        end else begin
          a_q    <= ys_q;
          b_q    <= xs_q;
          ae_q   <= ye_q;
          san_q  <= dy_q[CRD_W];
          sbn_q  <= dx_q[CRD_W];
          amax_q <= h_s;
          bmax_q <= w_s;
          da_q   <= db_q;
          db_q   <= da_q;
        end
      end
      S_LIM: begin
        if (san_q) begin
          lim_q <= ae_q[CRD_W-1] ? '0 : ae_q;
        end else begin
          lim_q <= (ae_q < amax_q) ? ae_q : (amax_q - ONE);
        end
        err_q   <= $signed({2'b00, da_q >> 1});
        ddiff_q <= $signed({2'b00, da_q}) - $signed({2'b00, db_q});
        pa_q    <= a_q;
        pb_q    <= b_q;
      end
      S_WALK: begin
        // check stage: data of the cell issued last cycle
        if (!obst && cv_q) begin
          pa_q <= ca_q;
          pb_q <= cb_q;
        end
        if (!obst && term_q && !cv_q && !term_hit_q) begin
          res_q <= '{hit: 1'b0, range_q4: '0};
        end
        if (issue) begin
          ca_q <= a_q;
          cb_q <= b_q;
        end
        if (!term_q) begin
          if (beyond) begin
            term_hit_q <= term_hit_a;
          end else begin
            if (b_move) begin
              if (b_out) begin
                term_hit_q <= 1'b1;
              end else begin
                b_q   <= b_step;
                err_q <= err_alt;
              end
            end else begin
              err_q <= err_dec;
            end
            if (!b_out) begin
              a_q <= a_step;
            end
          end
        end
      end
      S_DIST: begin
        ex_q <= exa[DW-1:0];
        ey_q <= eya[DW-1:0];
      end
      S_SQ: begin
        exx_q <= ex_q * ex_q;
        eyy_q <= ey_q * ey_q;
      end
      S_ROOT: begin
        if (sq_done) begin
          res_q <= '{hit: 1'b1, range_q4: range_sat};
        end
      end
      default: ;
    endcase
  end

`ifndef ASSERT_OFF
  a_rd_in_map: assert property (@(posedge clk_i) disable iff (!rst_ni)
    issue |-> (!rd_x[CRD_W-1] && (rd_x < MAX_WIDTH) &&
               !rd_y[CRD_W-1] && (rd_y < MAX_HEIGHT)))
    else $error("grid read outside map");

  a_check_follows_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cv_q |-> $past(issue))
    else $error("cell check without a read");

  a_miss_zero_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !res_o.hit) |-> (res_o.range_q4 == '0))
    else $error("miss with nonzero range");

  a_root_in_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sq_done |-> (state_q == S_ROOT))
    else $error("root finished outside wait state");
`endif

endmodule

### rtl/core/grid_ray_obstacle_cast_unit.sv
// Occupancy grid with Bresenham ray cast.
// Input stream (s_axis): tuser selects the word kind. A cell word writes one
// grid cell and yields no result; a ray word walks the grid from its start
// toward its end and yields one result word on m_axis.
// Config port: cfg_we_i writes cfg_data_i into register cfg_idx_i (0 map width,
// 1 map height, 2 obstacle value); write only while no ray is in flight.
// Cell word: written to the grid on acceptance; the input stays ready.
// Ray word: a start off the map goes from the check state straight to the
// result (a hit at range 0). Otherwise the walk does one grid memory read per
// cycle over the cells visited, then the square root of RW bits gives one
// result bit per cycle (RW is 13 at the default sizes).
// One ray is in work at a time; the next word is taken once the result is in
// the output register, so it can wait on m_axis_tready_i while work goes on.
// A stalled receiver holds the result; the unit stops before the next result.
// Reset clears control state and sets the registers to 256, 256 and 0. The
// grid is not cleared: every cell a ray may touch must be written first.
module grid_ray_obstacle_cast_unit #(
  parameter int MAX_WIDTH       = gro_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT      = gro_pkg::MAX_HEIGHT_DEF,
  parameter int RANGE_FRAC_BITS = gro_pkg::RANGE_FRAC_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  // cell_x, cell_y, cell_value, start_x, start_y, end_x, end_y
  input  logic [gro_pkg::IN_DATA_W-1:0]    s_axis_tdata_i,
  // kind
  input  logic                             s_axis_tuser_i,
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  // hit, range_q4, zero pad
  output logic [gro_pkg::OUT_DATA_W-1:0]   m_axis_tdata_o,
  input  logic                             cfg_we_i,
  input  logic [gro_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [gro_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import gro_pkg::*;

  logic [CFG_DATA_W-1:0] map_width_q, map_height_q;
  logic [CELL_W-1:0]     obstacle_q;
  logic                  out_valid_q;
  logic [OUT_DATA_W-1:0] out_data_q;

  gro_item_t item;
  gro_cfg_t  cfg;
  gro_res_t  res;
  logic      res_valid, res_ready;

  assign item.kind       = s_axis_tuser_i;
  assign item.cell_x     = s_axis_tdata_i[7:0];
  assign item.cell_y     = s_axis_tdata_i[15:8];
  assign item.cell_value = s_axis_tdata_i[23:16];
  assign item.start_x    = s_axis_tdata_i[39:24];
  assign item.start_y    = s_axis_tdata_i[55:40];
  assign item.end_x      = s_axis_tdata_i[71:56];
  assign item.end_y      = s_axis_tdata_i[87:72];

  assign cfg.width  = (map_width_q == '0) ? CRD_W'(1) :
                      (map_width_q > MAX_WIDTH) ? CRD_W'(MAX_WIDTH) : CRD_W'(map_width_q);
  assign cfg.height = (map_height_q == '0) ? CRD_W'(1) :
                      (map_height_q > MAX_HEIGHT) ? CRD_W'(MAX_HEIGHT) : CRD_W'(map_height_q);
  assign cfg.obstacle = obstacle_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_width_q  <= MAP_WIDTH_RST;
      map_height_q <= MAP_HEIGHT_RST;
      obstacle_q   <= OBSTACLE_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_MAP_WIDTH:  map_width_q  <= cfg_data_i;
        REG_MAP_HEIGHT: map_height_q <= cfg_data_i;
        REG_OBSTACLE:   obstacle_q   <= cfg_data_i[CELL_W-1:0];
        default: ;
      endcase
    end
  end

  gro_ray_ctrl #(
    .MAX_WIDTH       (MAX_WIDTH),
    .MAX_HEIGHT      (MAX_HEIGHT),
    .RANGE_FRAC_BITS (RANGE_FRAC_BITS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_item_i   (item),
    .cfg_i       (cfg),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  // output register
  assign res_ready = !out_valid_q || m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_data_q <= {{(OUT_DATA_W-RANGE_W-1){1'b0}}, res.range_q4, res.hit};
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule
